/* src/qte_pkg.sv */
package qte_pkg;

    // CORDIC datapath widths
    localparam int CW   = 38;  // x/y word, covers 2^33 inputs with gain and pre-rotation
    localparam int ZW   = 24;  // angle accumulator, Q.20
    localparam int SQ_N = 29;  // square root result bits (root <= 2^28)
    localparam int RW   = 60;  // square root remainder word

    localparam logic signed [33:0] ONE_Q28     = 34'sd268435456;
    localparam logic signed [33:0] NEG_ONE_Q28 = -34'sd268435456;
    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [15:0] PI_Q13      = 16'sd25736;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

    // atan(2^-i) in Q.20
    localparam logic signed [ZW-1:0] ATAN_Q20 [24] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
        24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
        24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
        24'sd256,    24'sd128,    24'sd64,     24'sd32,
        24'sd16,     24'sd8,      24'sd4,      24'sd2,
        24'sd1,      24'sd0,      24'sd0,      24'sd0
    };

    // atan2 operands carried alongside the square root
    typedef struct packed {
        logic signed [33:0] roll_y;
        logic signed [33:0] roll_x;
        logic signed [33:0] yaw_y;
        logic signed [33:0] yaw_x;
        logic signed [29:0] pitch_s;
    } t_operands;

endpackage

/* src/qte_quat_if.sv */
interface qte_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                    input quat_w, output ready);
endinterface

/* src/qte_euler_if.sv */
interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;

    modport source (output valid, output roll_angle, output pitch_angle,
                    output yaw_angle, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle,
                    input yaw_angle, output ready);
endinterface

/* src/quaternion_to_euler_angles.sv */
// Quaternion to roll/pitch/yaw. Takes one Q1.14 quaternion word per cycle, unless
// the output is stalled, and returns roll and yaw in Q3.13 and pitch in Q2.13
// radians, one result word per input word, in order. Fully pipelined: a new word
// can enter every cycle while the output is not stalled. The pipeline is one
// product stage, one sum/clamp stage, one square stage, 29 stages of the
// bit-per-stage square root for the pitch cosine term, one pre-rotation stage
// plus CORDIC_STAGES vectoring stages (three CORDICs side by side), and the
// rounding/saturating output register. The whole pipeline freezes only while
// the output register holds a word that is not taken; bubbles keep flowing in.
// No reset pass, no state between words.
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler
);

    localparam int N = 5 + SQ_N + CORDIC_STAGES;  // valid bits incl. output reg

    logic [N-1:0] r_vld;
    logic         w_en;

    // global advance: freeze only when the output word is stuck
    assign w_en         = !r_vld[N-1] || o_euler.ready;
    assign i_quat.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N-2:0], i_quat.valid};
        end
    end

    // ---- stage A: products, Q.28
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wx <= 32'(i_quat.quat_w) * 32'(i_quat.quat_x);
            r_yz <= 32'(i_quat.quat_y) * 32'(i_quat.quat_z);
            r_xx <= 32'(i_quat.quat_x) * 32'(i_quat.quat_x);
            r_yy <= 32'(i_quat.quat_y) * 32'(i_quat.quat_y);
            r_wy <= 32'(i_quat.quat_w) * 32'(i_quat.quat_y);
            r_zx <= 32'(i_quat.quat_z) * 32'(i_quat.quat_x);
            r_wz <= 32'(i_quat.quat_w) * 32'(i_quat.quat_z);
            r_xy <= 32'(i_quat.quat_x) * 32'(i_quat.quat_y);
            r_zz <= 32'(i_quat.quat_z) * 32'(i_quat.quat_z);
        end
    end

    // ---- stage B: product terms, pitch argument clamp to [-1, 1]
    logic signed [33:0] w_py;
    t_operands          n_b_ops, r_b_ops;

    always_comb begin
        n_b_ops.roll_y = (34'(r_wx) + 34'(r_yz)) <<< 1;
        n_b_ops.roll_x = ONE_Q28 - ((34'(r_xx) + 34'(r_yy)) <<< 1);
        n_b_ops.yaw_y  = (34'(r_wz) + 34'(r_xy)) <<< 1;
        n_b_ops.yaw_x  = ONE_Q28 - ((34'(r_yy) + 34'(r_zz)) <<< 1);
        w_py           = (34'(r_wy) - 34'(r_zx)) <<< 1;
        if (w_py > ONE_Q28) begin
            n_b_ops.pitch_s = ONE_Q28[29:0];
        end else if (w_py < NEG_ONE_Q28) begin
            n_b_ops.pitch_s = NEG_ONE_Q28[29:0];
        end else begin
            n_b_ops.pitch_s = w_py[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_ops <= n_b_ops;
        end
    end

    // ---- stage C: radicand 2^56 - s*s
    logic signed [RW-1:0] w_sq;
    logic        [RW-1:0] r_c_rem;
    t_operands            r_c_ops;

    assign w_sq = r_b_ops.pitch_s * r_b_ops.pitch_s;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_rem <= (RW'(1) << 56) - $unsigned(w_sq);
            r_c_ops <= r_b_ops;
        end
    end

    // ---- square root, one result bit per stage, MSB first
    logic [RW-1:0]   r_s_rem [SQ_N];
    logic [SQ_N-1:0] r_s_res [SQ_N];
    t_operands       r_s_ops [SQ_N];

    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        localparam int K = SQ_N - 1 - j;
        logic [RW-1:0]   w_rem_in;
        logic [SQ_N-1:0] w_res_in;
        t_operands       w_ops_in;
        logic [RW-1:0]   w_delta;

        if (j == 0) begin : g_first
            assign w_rem_in = r_c_rem;
            assign w_res_in = '0;
            assign w_ops_in = r_c_ops;
        end else begin : g_next
            assign w_rem_in = r_s_rem[j-1];
            assign w_res_in = r_s_res[j-1];
            assign w_ops_in = r_s_ops[j-1];
        end

        // (res + 2^K)^2 - res^2
        assign w_delta = (RW'(w_res_in) << (K + 1)) + (RW'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s_ops[j] <= w_ops_in;
                if (w_rem_in >= w_delta) begin
                    r_s_rem[j] <= w_rem_in - w_delta;
                    r_s_res[j] <= w_res_in | (SQ_N'(1) << K);
                end else begin
                    r_s_rem[j] <= w_rem_in;
                    r_s_res[j] <= w_res_in;
                end
            end
        end
    end

    // ---- three vectoring CORDICs
    t_operands            w_ops;
    logic signed [ZW-1:0] w_roll_z, w_pitch_z, w_yaw_z;
    logic                 w_roll_0, w_pitch_0, w_yaw_0;

    assign w_ops = r_s_ops[SQ_N-1];

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (CW'(w_ops.roll_x)),
        .i_y    (CW'(w_ops.roll_y)),
        .o_z    (w_roll_z),
        .o_zero (w_roll_0)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    ($signed({{(CW-SQ_N){1'b0}}, r_s_res[SQ_N-1]})),
        .i_y    (CW'(w_ops.pitch_s)),
        .o_z    (w_pitch_z),
        .o_zero (w_pitch_0)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (CW'(w_ops.yaw_x)),
        .i_y    (CW'(w_ops.yaw_y)),
        .o_z    (w_yaw_z),
        .o_zero (w_yaw_0)
    );

    // ---- output: Q.20 -> Q.13 round (ties up), saturate, atan2(0,0) = 0
    function automatic logic signed [15:0] f_angle(
        input logic signed [ZW-1:0] z,
        input logic                 zero,
        input logic signed [15:0]   lim
    );
        logic signed [ZW-1:0] sum;
        logic signed [ZW-8:0] q;
        sum = z + 24'sd64;
        q   = sum[ZW-1:7];
        if (zero) begin
            return '0;
        end else if (q > lim) begin
            return lim;
        end else if (q < -lim) begin
            return -lim;
        end else begin
            return q[15:0];
        end
    endfunction

    logic signed [15:0] w_pitch;
    logic signed [15:0] r_roll, r_yaw;
    logic signed [14:0] r_pitch;

    assign w_pitch = f_angle(w_pitch_z, w_pitch_0, HALF_PI_Q13);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll  <= f_angle(w_roll_z, w_roll_0, PI_Q13);
            r_pitch <= w_pitch[14:0];
            r_yaw   <= f_angle(w_yaw_z, w_yaw_0, PI_Q13);
        end
    end

    assign o_euler.valid       = r_vld[N-1];
    assign o_euler.roll_angle  = r_roll;
    assign o_euler.pitch_angle = r_pitch;
    assign o_euler.yaw_angle   = r_yaw;

    // ---- checks
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_euler.valid && !o_euler.ready) |-> !i_quat.ready)
        else $error("input taken while output word is stuck");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> (o_euler.roll_angle <= PI_Q13 && o_euler.roll_angle >= -PI_Q13))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> (16'(o_euler.pitch_angle) <= HALF_PI_Q13
                           && 16'(o_euler.pitch_angle) >= -HALF_PI_Q13))
        else $error("pitch out of range");

endmodule

/* src/qte_cordic.sv */
module qte_cordic import qte_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic signed [ZW-1:0] o_z,
    output logic                 o_zero
);

    logic signed [CW-1:0] r_x    [STAGES+1];
    logic signed [CW-1:0] r_y    [STAGES+1];
    logic signed [ZW-1:0] r_z    [STAGES+1];
    logic                 r_zero [STAGES+1];

    // left half-plane: turn by 90 degrees first
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[CW-1]) begin
                if (!i_y[CW-1]) begin
                    r_x[0] <= i_y;
                    r_y[0] <= -i_x;
                    r_z[0] <= HALF_PI_Q20;
                end else begin
                    r_x[0] <= -i_y;
                    r_y[0] <= i_x;
                    r_z[0] <= -HALF_PI_Q20;
                end
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN_Q20[i];
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN_Q20[i];
                end
            end
        end
    end

    assign o_z    = r_z[STAGES];
    assign o_zero = r_zero[STAGES];

endmodule
